FILE: rtl/prjr_pkg.sv
// Shared types, constants and fixed-point helpers for the reprojection unit.
package prjr_pkg;

  localparam int DIV_LAT  = 32;
  localparam int POST_LAT = DIV_LAT - 4;

  localparam logic [2:0] REG_FOCAL_X     = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
  localparam logic [2:0] REG_CENTER_X    = 3'd2;
  localparam logic [2:0] REG_CENTER_Y    = 3'd3;
  localparam logic [2:0] REG_POINT_SCALE = 3'd4;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [65:0] ONE_Q30 = 66'sd1073741824;

  typedef enum logic [1:0] {
    KIND_RESID  = 2'd0,
    KIND_POSE_U = 2'd1,
    KIND_POSE_V = 2'd2,
    KIND_POINT  = 2'd3
  } kind_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] v;
  } sat_t;

  typedef struct packed {
    logic [2:0][2:0][31:0] rot;
    logic [31:0]           su;
    logic [31:0]           sv;
    logic [31:0]           z;
    logic                  fault;
  } side_t;

  typedef struct packed {
    logic [3:0][6:0][31:0] res;
    logic                  fault;
  } post_t;

  function automatic logic signed [65:0] sx32(input logic [31:0] a);
    return 66'($signed(a));
  endfunction

  function automatic sat_t sat32(input logic signed [65:0] a);
    sat_t r;
    if (a > S32_MAX) begin
      r.hit = 1'b1;
      r.v   = 32'h7fff_ffff;
    end else if (a < S32_MIN) begin
      r.hit = 1'b1;
      r.v   = 32'h8000_0000;
    end else begin
      r.hit = 1'b0;
      r.v   = a[31:0];
    end
    return r;
  endfunction

  function automatic sat_t qmul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return sat32(66'(p >>> 16));
  endfunction

  function automatic logic [33:0] mul_shr30(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return p[63:30];
  endfunction

endpackage

FILE: rtl/prjr_div.sv
// Pipelined restoring divider: floor of a signed 64-bit numerator by a positive divisor.
module prjr_div import prjr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic        ovf
);

  logic [31:0] rem [DIV_LAT];
  logic [30:0] sh  [DIV_LAT];
  logic [31:0] dv  [DIV_LAT];
  logic        ng  [DIV_LAT];
  logic        of  [DIV_LAT];

  logic [62:0] mag;
  logic [32:0] trial [DIV_LAT-1];
  logic        ge    [DIV_LAT-1];
  logic [32:0] diff  [DIV_LAT-1];

  // A negative numerator n is divided as ~n, and the quotient is inverted back.
  assign mag = num[63] ? ~num[62:0] : num[62:0];

  always_comb begin
    for (int k = 0; k < DIV_LAT - 1; k++) begin
      trial[k] = {rem[k], sh[k][30]};
      ge[k]    = trial[k] >= {1'b0, dv[k]};
      diff[k]  = trial[k] - {1'b0, dv[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= mag[62:31];
      sh[0]  <= mag[30:0];
      dv[0]  <= den;
      ng[0]  <= num[63];
      of[0]  <= mag[62:31] >= den;
      for (int k = 1; k < DIV_LAT; k++) begin
        rem[k] <= ge[k-1] ? diff[k-1][31:0] : trial[k-1][31:0];
        sh[k]  <= {sh[k-1][29:0], ge[k-1]};
        dv[k]  <= dv[k-1];
        ng[k]  <= ng[k-1];
        of[k]  <= of[k-1];
      end
    end
  end

  always_comb begin
    if (of[DIV_LAT-1]) begin
      quo = ng[DIV_LAT-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      quo = ng[DIV_LAT-1] ? ~{1'b0, sh[DIV_LAT-1]} : {1'b0, sh[DIV_LAT-1]};
    end
  end

  assign ovf = of[DIV_LAT-1];

endmodule

FILE: rtl/pinhole_reprojection_residual_jacobian_unit.sv
// Pinhole reprojection residual and Jacobian unit, top level.
//
//   channel | direction | beat content
//   s_*     | in        | one pose, map point and observed pixel
//   m_*     | out       | four beats per input: residuals, pose row u, pose row v, point
//   cfg_*   | in        | register write, no read-back
//
// Two chained 32-stage divider pipelines make up most of the datapath.
// The four-beat output register takes a new item as the old one's last beat is taken.
// Reset clears the valid bits and loads the configuration registers with defaults.
// All stages hold while the last stage has a result that the output register cannot take.
module pinhole_reprojection_residual_jacobian_unit import prjr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // trans_x, trans_y, trans_z, quat_x, quat_y, quat_z, quat_w, world_x, world_y,
  // world_z, seen_u, seen_v
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // val0, val1, val2, val3, val4, val5, val6
  output logic [223:0] m_tdata,
  // kind, fault (non-positive depth, saturation or divider overflow)
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [30:0] focal_x;
  logic [30:0] focal_y;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] point_scale;

  logic adv;

  logic v1, v2, v3, v4, v5, v6;
  logic side_v [DIV_LAT];
  logic vp1, vp2, vp3, vp4;
  logic post_v [POST_LAT];

  logic [383:0] s1_d, s2_d, s3_d, s4_d;
  logic [8:0][33:0] s2_qq;
  logic [2:0][2:0][31:0] s3_rot, s4_rot, s5_rot;
  logic s3_fault, s4_fault, s5_fault;
  logic [2:0][2:0][33:0] s4_rp;
  logic [31:0] s5_x, s5_y, s5_z, s5_su, s5_sv;
  logic [7:0][63:0] s6_num;
  side_t s6_side;

  side_t side_line [DIV_LAT];
  side_t sd;
  logic [31:0] d1_q [8];
  logic        d1_ovf [8];

  logic [31:0] p1_ru, p1_rv, p1_fzx, p1_fzy, p1_r15, p1_r25x;
  logic [31:0] p1_qpy, p1_qpx, p1_qvy, p1_qvx;
  logic [2:0][63:0] p1_pa, p1_pb;
  logic [1:0][2:0][31:0] p1_rot;
  logic p1_fault;
  logic [63:0] d2_num [2];
  logic [31:0] d2_q [2];
  logic        d2_ovf [2];

  post_t p2_res, p3_res, p4_res;
  post_t p2_next, p3_next, p4_next;
  logic [31:0] p2_ruru, p2_rvrv, p2_fzx, p2_fzy;
  logic [2:0][31:0] p2_a, p2_b, p3_fa, p3_fb;

  post_t post_line [POST_LAT];
  post_t fin;
  post_t hold_res;
  logic  hold_valid;
  kind_t hold_kind;

  // Configuration registers and handshake control.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x     <= 31'd32768000;
      focal_y     <= 31'd32768000;
      center_x    <= 32'd20971520;
      center_y    <= 32'd15728640;
      point_scale <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL_X:     focal_x     <= cfg_data[30:0];
        REG_FOCAL_Y:     focal_y     <= cfg_data[30:0];
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        REG_POINT_SCALE: point_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !post_v[POST_LAT-1] || !hold_valid || (m_tready && m_tlast);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      vp1 <= 1'b0; vp2 <= 1'b0; vp3 <= 1'b0; vp4 <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) side_v[k] <= 1'b0;
      for (int k = 0; k < POST_LAT; k++) post_v[k] <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      side_v[0] <= v6;
      for (int k = 1; k < DIV_LAT; k++) side_v[k] <= side_v[k-1];
      vp1 <= side_v[DIV_LAT-1]; vp2 <= vp1; vp3 <= vp2; vp4 <= vp3;
      post_v[0] <= vp4;
      for (int k = 1; k < POST_LAT; k++) post_v[k] <= post_v[k-1];
    end
  end

  // Rotation, transform and divider operand stages.
  sat_t r_s [3][3];
  sat_t x_s [3];
  logic signed [65:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_xw, e_yw, e_zw;

  always_comb begin
    e_xx = 66'($signed(s2_qq[0])); e_yy = 66'($signed(s2_qq[1]));
    e_zz = 66'($signed(s2_qq[2])); e_xy = 66'($signed(s2_qq[3]));
    e_xz = 66'($signed(s2_qq[4])); e_yz = 66'($signed(s2_qq[5]));
    e_xw = 66'($signed(s2_qq[6])); e_yw = 66'($signed(s2_qq[7]));
    e_zw = 66'($signed(s2_qq[8]));
    r_s[0][0] = sat32(ONE_Q30 - ((e_yy + e_zz) <<< 1));
    r_s[0][1] = sat32((e_xy - e_zw) <<< 1);
    r_s[0][2] = sat32((e_xz + e_yw) <<< 1);
    r_s[1][0] = sat32((e_xy + e_zw) <<< 1);
    r_s[1][1] = sat32(ONE_Q30 - ((e_xx + e_zz) <<< 1));
    r_s[1][2] = sat32((e_yz - e_xw) <<< 1);
    r_s[2][0] = sat32((e_xz - e_yw) <<< 1);
    r_s[2][1] = sat32((e_yz + e_xw) <<< 1);
    r_s[2][2] = sat32(ONE_Q30 - ((e_xx + e_yy) <<< 1));
    for (int i = 0; i < 3; i++) begin
      x_s[i] = sat32(sx32(s4_d[32*i +: 32]) + 66'($signed(s4_rp[i][0]))
                     + 66'($signed(s4_rp[i][1])) + 66'($signed(s4_rp[i][2])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d <= s_tdata;

      s2_d     <= s1_d;
      s2_qq[0] <= mul_shr30(s1_d[96 +: 32],  s1_d[96 +: 32]);
      s2_qq[1] <= mul_shr30(s1_d[128 +: 32], s1_d[128 +: 32]);
      s2_qq[2] <= mul_shr30(s1_d[160 +: 32], s1_d[160 +: 32]);
      s2_qq[3] <= mul_shr30(s1_d[96 +: 32],  s1_d[128 +: 32]);
      s2_qq[4] <= mul_shr30(s1_d[96 +: 32],  s1_d[160 +: 32]);
      s2_qq[5] <= mul_shr30(s1_d[128 +: 32], s1_d[160 +: 32]);
      s2_qq[6] <= mul_shr30(s1_d[96 +: 32],  s1_d[192 +: 32]);
      s2_qq[7] <= mul_shr30(s1_d[128 +: 32], s1_d[192 +: 32]);
      s2_qq[8] <= mul_shr30(s1_d[160 +: 32], s1_d[192 +: 32]);

      s3_d     <= s2_d;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_rot[i][j] <= r_s[i][j].v;
        end
      end
      s3_fault <= r_s[0][0].hit | r_s[0][1].hit | r_s[0][2].hit
                | r_s[1][0].hit | r_s[1][1].hit | r_s[1][2].hit
                | r_s[2][0].hit | r_s[2][1].hit | r_s[2][2].hit;

      s4_d     <= s3_d;
      s4_rot   <= s3_rot;
      s4_fault <= s3_fault;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s4_rp[i][j] <= mul_shr30(s3_rot[i][j], s3_d[224 + 32*j +: 32]);
        end
      end

      s5_rot <= s4_rot;
      s5_su  <= s4_d[320 +: 32];
      s5_sv  <= s4_d[352 +: 32];
      s5_x   <= x_s[0].v;
      s5_y   <= x_s[1].v;
      if (x_s[2].v[31] || x_s[2].v == 32'd0) begin
        s5_z     <= 32'd1;
        s5_fault <= 1'b1;
      end else begin
        s5_z     <= x_s[2].v;
        s5_fault <= s4_fault | x_s[0].hit | x_s[1].hit | x_s[2].hit;
      end

      s6_num[0] <= {{16{s5_x[31]}}, s5_x, 16'd0};
      s6_num[1] <= {{16{s5_y[31]}}, s5_y, 16'd0};
      s6_num[2] <= {17'd0, focal_x, 16'd0};
      s6_num[3] <= {17'd0, focal_y, 16'd0};
      s6_num[4] <= $signed(s5_x) * $signed({1'b0, focal_x});
      s6_num[5] <= $signed(s5_y) * $signed({1'b0, focal_y});
      s6_num[6] <= $signed(s5_y) * $signed({1'b0, focal_x});
      s6_num[7] <= $signed(s5_x) * $signed({1'b0, focal_y});
      s6_side.rot   <= s5_rot;
      s6_side.su    <= s5_su;
      s6_side.sv    <= s5_sv;
      s6_side.z     <= s5_z;
      s6_side.fault <= s5_fault;

      side_line[0] <= s6_side;
      for (int k = 1; k < DIV_LAT; k++) side_line[k] <= side_line[k-1];
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_div1
    prjr_div u_div (
      .clk (clk),
      .en  (adv),
      .num (s6_num[g]),
      .den (s6_side.z),
      .quo (d1_q[g]),
      .ovf (d1_ovf[g])
    );
  end

  // Post-division arithmetic; quotients are xn, yn, fx/z, fy/z, pu, pv, y*fx/z, x*fy/z.
  sat_t ru_s, rv_s, qpy_s, qpx_s, qvy_s, qvx_s;
  sat_t ruru_s, rvrv_s, r10_s, r21_s, r14_s, r23_s, r24_s, r25_s, cost_s;
  sat_t a_s [3];
  sat_t b_s [3];
  sat_t fa_s [3];
  sat_t fb_s [3];
  sat_t s3a_s [3];
  sat_t s3b_s [3];
  logic d1_any_ovf;

  assign sd = side_line[DIV_LAT-1];
  assign d2_num[0] = {{16{d1_q[4][31]}}, d1_q[4], 16'd0};
  assign d2_num[1] = {{16{d1_q[5][31]}}, d1_q[5], 16'd0};

  always_comb begin
    d1_any_ovf = d1_ovf[0] | d1_ovf[1] | d1_ovf[2] | d1_ovf[3]
               | d1_ovf[4] | d1_ovf[5] | d1_ovf[6] | d1_ovf[7];
    ru_s  = sat32(sx32(sd.su) - sx32(center_x) - sx32(d1_q[4]));
    rv_s  = sat32(sx32(sd.sv) - sx32(center_y) - sx32(d1_q[5]));
    qpy_s = qmul(d1_q[4], d1_q[1]);
    qpx_s = qmul(d1_q[4], d1_q[0]);
    qvy_s = qmul(d1_q[5], d1_q[1]);
    qvx_s = qmul(d1_q[5], d1_q[0]);

    ruru_s = qmul(p1_ru, p1_ru);
    rvrv_s = qmul(p1_rv, p1_rv);
    r10_s  = sat32(-sx32(p1_fzx));
    r21_s  = sat32(-sx32(p1_fzy));
    r14_s  = sat32(-sx32({1'b0, focal_x}) - sx32(p1_qpx));
    r23_s  = sat32(sx32({1'b0, focal_y}) + sx32(p1_qvy));
    r24_s  = sat32(-sx32(p1_qvx));
    r25_s  = sat32(-sx32(p1_r25x));
    for (int j = 0; j < 3; j++) begin
      a_s[j] = sat32((66'($signed(p1_pa[j])) - (sx32(p1_rot[0][j]) <<< 16)) >>> 30);
      b_s[j] = sat32((66'($signed(p1_pb[j])) - (sx32(p1_rot[1][j]) <<< 16)) >>> 30);
    end

    cost_s = sat32(sx32(p2_ruru) + sx32(p2_rvrv));
    for (int j = 0; j < 3; j++) begin
      fa_s[j]  = qmul(p2_fzx, p2_a[j]);
      fb_s[j]  = qmul(p2_fzy, p2_b[j]);
      s3a_s[j] = qmul(point_scale, p3_fa[j]);
      s3b_s[j] = qmul(point_scale, p3_fb[j]);
    end
  end

  always_comb begin
    p2_next          = '0;
    p2_next.res[0][0] = p1_ru;
    p2_next.res[0][1] = p1_rv;
    p2_next.res[1][0] = r10_s.v;
    p2_next.res[1][3] = p1_qpy;
    p2_next.res[1][4] = r14_s.v;
    p2_next.res[1][5] = p1_r15;
    p2_next.res[2][1] = r21_s.v;
    p2_next.res[2][3] = r23_s.v;
    p2_next.res[2][4] = r24_s.v;
    p2_next.res[2][5] = r25_s.v;
    p2_next.fault = p1_fault | ruru_s.hit | rvrv_s.hit | r10_s.hit | r21_s.hit
                  | r14_s.hit | r23_s.hit | r24_s.hit | r25_s.hit
                  | a_s[0].hit | a_s[1].hit | a_s[2].hit
                  | b_s[0].hit | b_s[1].hit | b_s[2].hit;

    p3_next           = p2_res;
    p3_next.res[0][2] = cost_s.v;
    p3_next.fault = p2_res.fault | cost_s.hit | fa_s[0].hit | fa_s[1].hit | fa_s[2].hit
                  | fb_s[0].hit | fb_s[1].hit | fb_s[2].hit;

    p4_next = p3_res;
    for (int j = 0; j < 3; j++) begin
      p4_next.res[3][j]     = s3a_s[j].v;
      p4_next.res[3][3 + j] = s3b_s[j].v;
    end
    p4_next.fault = p3_res.fault | s3a_s[0].hit | s3a_s[1].hit | s3a_s[2].hit
                  | s3b_s[0].hit | s3b_s[1].hit | s3b_s[2].hit;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ru   <= ru_s.v;
      p1_rv   <= rv_s.v;
      p1_fzx  <= d1_q[2];
      p1_fzy  <= d1_q[3];
      p1_r15  <= d1_q[6];
      p1_r25x <= d1_q[7];
      p1_qpy  <= qpy_s.v;
      p1_qpx  <= qpx_s.v;
      p1_qvy  <= qvy_s.v;
      p1_qvx  <= qvx_s.v;
      for (int j = 0; j < 3; j++) begin
        p1_pa[j] <= $signed(d1_q[0]) * $signed(sd.rot[2][j]);
        p1_pb[j] <= $signed(d1_q[1]) * $signed(sd.rot[2][j]);
      end
      p1_rot   <= sd.rot[1:0];
      p1_fault <= sd.fault | d1_any_ovf | ru_s.hit | rv_s.hit
                | qpy_s.hit | qpx_s.hit | qvy_s.hit | qvx_s.hit;

      p2_ruru <= ruru_s.v;
      p2_rvrv <= rvrv_s.v;
      p2_fzx  <= p1_fzx;
      p2_fzy  <= p1_fzy;
      for (int j = 0; j < 3; j++) begin
        p2_a[j] <= a_s[j].v;
        p2_b[j] <= b_s[j].v;
      end
      p2_res <= p2_next;

      p3_res <= p3_next;
      for (int j = 0; j < 3; j++) begin
        p3_fa[j] <= fa_s[j].v;
        p3_fb[j] <= fb_s[j].v;
      end

      p4_res <= p4_next;

      post_line[0] <= p4_res;
      for (int k = 1; k < POST_LAT; k++) post_line[k] <= post_line[k-1];
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_div2
    prjr_div u_div (
      .clk (clk),
      .en  (adv),
      .num (d2_num[g]),
      .den (sd.z),
      .quo (d2_q[g]),
      .ovf (d2_ovf[g])
    );
  end

  always_comb begin
    fin           = post_line[POST_LAT-1];
    fin.res[1][2] = d2_q[0];
    fin.res[2][2] = d2_q[1];
    fin.fault     = post_line[POST_LAT-1].fault | d2_ovf[0] | d2_ovf[1];
  end

  // Output register: one item, sent as four beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_kind  <= KIND_RESID;
    end else if (adv && post_v[POST_LAT-1]) begin
      hold_valid <= 1'b1;
      hold_kind  <= KIND_RESID;
    end else if (hold_valid && m_tready) begin
      if (hold_kind == KIND_POINT) begin
        hold_valid <= 1'b0;
      end else begin
        hold_kind <= kind_t'(hold_kind + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && post_v[POST_LAT-1]) begin
      hold_res <= fin;
    end
  end

  assign m_tvalid = hold_valid;
  assign m_tdata  = hold_res.res[hold_kind];
  assign m_tuser  = {hold_res.fault, hold_kind};
  assign m_tlast  = hold_kind == KIND_POINT;

  a_fault_steady: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser[2] == $past(m_tuser[2])))
    else $error("fault flag changed within one item");

  a_kind_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tuser[1:0] == 2'($past(m_tuser[1:0]) + 2'd1)))
    else $error("result kinds out of order");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !(m_tready && m_tlast)))
    else $error("input stalled without a blocked output");

endmodule

FILE: bench/tb_pinhole_reprojection_residual_jacobian_unit.sv
// Self-checking testbench for the pinhole reprojection residual and Jacobian unit.
module tb_pinhole_reprojection_residual_jacobian_unit import prjr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic last;
    logic fault;
    logic [6:0][31:0] vals;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [383:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [223:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_FOCAL_X;
  logic [31:0] cfg_data = '0;

  longint fx_q, fy_q, cx_q, cy_q, scale_q;
  beat_t expected_beats[$];
  int mismatches = 0;
  bit sink_hold = 1'b0;
  bit sink_noidle = 1'b0;
  bit src_noidle = 1'b0;

  pinhole_reprojection_residual_jacobian_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q -= 1;
    return q;
  endfunction

  function automatic longint clip(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fmul16(longint a, longint b, ref bit hit);
    return clip(fshr(a * b, 16), hit);
  endfunction

  function automatic longint fquo(longint n, longint d, ref bit hit);
    return clip(fdiv(n, d), hit);
  endfunction

  task automatic predict_reprojection(input logic [383:0] d);
    longint t[3], q[4], p[3], r[3][3], xc[3];
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
    longint su, sv, x, y, z, xn, yn, fzx, fzy, pu, pv, ru, rv, acc, a, b;
    longint v[4][7];
    bit hit, fault;
    beat_t e;
    hit = 1'b0;
    fault = 1'b0;
    for (int i = 0; i < 3; i++) t[i] = longint'($signed(d[32*i +: 32]));
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(d[32*(3+i) +: 32]));
    for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[32*(7+i) +: 32]));
    su = longint'($signed(d[320 +: 32]));
    sv = longint'($signed(d[352 +: 32]));
    xx = fshr(q[0]*q[0], 30); yy = fshr(q[1]*q[1], 30); zz = fshr(q[2]*q[2], 30);
    xy = fshr(q[0]*q[1], 30); xz = fshr(q[0]*q[2], 30); yz = fshr(q[1]*q[2], 30);
    xw = fshr(q[0]*q[3], 30); yw = fshr(q[1]*q[3], 30); zw = fshr(q[2]*q[3], 30);
    r[0][0] = clip((64'sd1 << 30) - 2*(yy+zz), hit);
    r[0][1] = clip(2*(xy-zw), hit);
    r[0][2] = clip(2*(xz+yw), hit);
    r[1][0] = clip(2*(xy+zw), hit);
    r[1][1] = clip((64'sd1 << 30) - 2*(xx+zz), hit);
    r[1][2] = clip(2*(yz-xw), hit);
    r[2][0] = clip(2*(xz-yw), hit);
    r[2][1] = clip(2*(yz+xw), hit);
    r[2][2] = clip((64'sd1 << 30) - 2*(xx+yy), hit);
    for (int i = 0; i < 3; i++) begin
      acc = t[i];
      for (int j = 0; j < 3; j++) acc += fshr(r[i][j]*p[j], 30);
      xc[i] = clip(acc, hit);
    end
    x = xc[0]; y = xc[1]; z = xc[2];
    if (z <= 0) begin
      fault = 1'b1;
      z = 1;
    end
    xn = fquo(x*65536, z, hit);
    yn = fquo(y*65536, z, hit);
    fzx = fquo(fx_q*65536, z, hit);
    fzy = fquo(fy_q*65536, z, hit);
    pu = fquo(x*fx_q, z, hit);
    pv = fquo(y*fy_q, z, hit);
    ru = clip(su - cx_q - pu, hit);
    rv = clip(sv - cy_q - pv, hit);
    v = '{default: 0};
    v[0][0] = ru; v[0][1] = rv;
    v[0][2] = clip(fmul16(ru, ru, hit) + fmul16(rv, rv, hit), hit);
    v[1][0] = clip(-fzx, hit);
    v[1][2] = fquo(pu*65536, z, hit);
    v[1][3] = fmul16(pu, yn, hit);
    v[1][4] = clip(-fx_q - fmul16(pu, xn, hit), hit);
    v[1][5] = fquo(y*fx_q, z, hit);
    v[2][1] = clip(-fzy, hit);
    v[2][2] = fquo(pv*65536, z, hit);
    v[2][3] = clip(fy_q + fmul16(pv, yn, hit), hit);
    v[2][4] = clip(-fmul16(pv, xn, hit), hit);
    v[2][5] = clip(-fquo(x*fy_q, z, hit), hit);
    for (int j = 0; j < 3; j++) begin
      a = clip(fshr(xn*r[2][j] - r[0][j]*65536, 30), hit);
      b = clip(fshr(yn*r[2][j] - r[1][j]*65536, 30), hit);
      v[3][j] = fmul16(scale_q, fmul16(fzx, a, hit), hit);
      v[3][3+j] = fmul16(scale_q, fmul16(fzy, b, hit), hit);
    end
    fault |= hit;
    for (int k = 0; k < 4; k++) begin
      e.kind = k[1:0];
      e.last = (k == 3);
      e.fault = fault;
      for (int i = 0; i < 7; i++) e.vals[i] = v[k][i][31:0];
      expected_beats.push_back(e);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FOCAL_X: fx_q = longint'(val[30:0]);
      REG_FOCAL_Y: fy_q = longint'(val[30:0]);
      REG_CENTER_X: cx_q = longint'($signed(val));
      REG_CENTER_Y: cy_q = longint'($signed(val));
      REG_POINT_SCALE: scale_q = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic send_pose(input logic [383:0] d);
    int gap;
    gap = src_noidle ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_reprojection(d);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_beats.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [383:0] pack_pose(longint t[3], longint q[4], longint p[3],
                                             longint u, longint w);
    logic [383:0] d;
    for (int i = 0; i < 3; i++) d[32*i +: 32] = t[i][31:0];
    for (int i = 0; i < 4; i++) d[32*(3+i) +: 32] = q[i][31:0];
    for (int i = 0; i < 3; i++) d[32*(7+i) +: 32] = p[i][31:0];
    d[320 +: 32] = u[31:0];
    d[352 +: 32] = w[31:0];
    return d;
  endfunction

  function automatic logic [383:0] sane_pose();
    longint t[3], q[4], p[3];
    int ang;
    for (int i = 0; i < 3; i++) begin
      t[i] = $signed($urandom_range(0, 20*65536)) - 10*65536;
      p[i] = $signed($urandom_range(0, 40*65536)) - 20*65536;
    end
    t[2] = $urandom_range(5*65536, 60*65536);
    ang = $urandom_range(0, 3);
    q[3] = (64'sd1 << 30) - $urandom_range(0, 1 << 26);
    for (int i = 0; i < 3; i++) q[i] = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
    if (ang == 0) q = '{0, 0, 0, 64'sd1 << 30};
    return pack_pose(t, q, p, $urandom_range(0, 640*65536), $urandom_range(0, 480*65536));
  endfunction

  function automatic logic [383:0] wild_pose();
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = $urandom;
    return d;
  endfunction

  task automatic test_directed();
    longint t[3], q[4], p[3];
    t = '{0, 0, 10*65536};
    q = '{0, 0, 0, 64'sd1 << 30};
    p = '{65536, -65536, 0};
    send_pose(pack_pose(t, q, p, 320*65536, 240*65536));
    t = '{0, 0, 0};
    send_pose(pack_pose(t, q, p, 0, 0));
    t = '{0, 0, -5*65536};
    send_pose(pack_pose(t, q, p, 100, 100));
    t = '{0, 0, 1};
    send_pose(pack_pose(t, q, p, 0, 0));
    send_pose({12{32'h7fff_ffff}});
    send_pose({12{32'h8000_0000}});
    send_pose({12{32'hffff_ffff}});
    send_pose('0);
    q = '{64'sd1 << 30, 0, 0, 0};
    t = '{65536, 2*65536, 8*65536};
    send_pose(pack_pose(t, q, p, -64'sd2147483648, 64'sd2147483647));
    q = '{0, 64'sd1 << 30, 0, 0};
    send_pose(pack_pose(t, q, p, 5*65536, 7*65536));
    q = '{0, 0, 64'sd1 << 30, 0};
    send_pose(pack_pose(t, q, p, 5*65536, 7*65536));
    q = '{64'sd1 << 31, 64'sd1 << 31, 0, 64'sd1 << 31};
    send_pose(pack_pose(t, q, p, 5*65536, 7*65536));
    for (int i = 0; i < 6; i++) send_pose(sane_pose());
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_pose($urandom_range(0, 4) == 0 ? wild_pose() : sane_pose());
    drain();
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    src_noidle = 1'b1;
    fork
      for (int i = 0; i < 100; i++) send_pose(sane_pose());
      begin
        repeat (600) @(negedge clk);
        sink_hold = 1'b0;
      end
    join
    src_noidle = 1'b0;
    drain();
  endtask

  task automatic test_full_rate(input int n);
    src_noidle = 1'b1;
    sink_noidle = 1'b1;
    for (int i = 0; i < n; i++) send_pose(sane_pose());
    src_noidle = 1'b0;
    sink_noidle = 1'b0;
    drain();
  endtask

  task automatic set_camera(input logic [31:0] f0, input logic [31:0] f1,
                            input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] sc);
    write_reg(REG_FOCAL_X, f0);
    write_reg(REG_FOCAL_Y, f1);
    write_reg(REG_CENTER_X, c0);
    write_reg(REG_CENTER_Y, c1);
    write_reg(REG_POINT_SCALE, sc);
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser[1:0];
      got.fault = m_tuser[2];
      got.last = m_tlast;
      got.vals = m_tdata;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    forever begin
      @(negedge clk);
      if (sink_hold) m_tready <= 1'b0;
      else if (sink_noidle) m_tready <= 1'b1;
      else begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        if (wait_cycles == 0) m_tready <= 1'b1;
        else begin
          m_tready <= 1'b0;
          repeat (wait_cycles - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    fx_q = 32768000;
    fy_q = 32768000;
    cx_q = 20971520;
    cy_q = 15728640;
    scale_q = 65536;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(60);
    test_backpressure();
    set_camera(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    test_random(40);
    set_camera(32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    test_random(40);
    set_camera(32'd19660800, 32'd26214400, 32'd20971520, 32'd15728640, 32'hffff_0000);
    test_full_rate(60);
    set_camera($urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(60);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
